// ===== sv/ins_sort_pkg.sv =====
`timescale 1ns / 1ps

package ins_sort_pkg;

	// Store depth default and data width
	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;

	// Sorter control states
	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} ins_sort_state_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;   // place the broadcast value into the chain
		logic shift;    // move every entry one cell toward the head
	} ins_sort_cmd_t;

endpackage

// ===== sv/ins_sort_cell.sv =====
`timescale 1ns / 1ps

module ins_sort_cell import ins_sort_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ins_sort_cmd_t             cmd,
	input  logic signed [DATA_W-1:0]  new_val,
	// neighbor toward the head
	input  logic                      left_ins,
	input  logic                      left_vld,
	input  logic signed [DATA_W-1:0]  left_val,
	// neighbor toward the tail
	input  logic                      right_vld,
	input  logic signed [DATA_W-1:0]  right_val,
	output logic                      ins,
	output logic                      vld,
	output logic signed [DATA_W-1:0]  val
);

	logic                     vld_q;
	logic signed [DATA_W-1:0] val_q;

	// Insertion point at or before this cell: empty, or held value >= new value
	assign ins = !vld_q || (val_q >= new_val);
	assign vld = vld_q;
	assign val = val_q;

	// Occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.shift) begin
			vld_q <= right_vld;
		end else if (cmd.insert && ins) begin
			vld_q <= left_ins ? left_vld : 1'b1;
		end
	end

	// Value: right neighbor's on shift; new value at insertion point, else left's
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			val_q <= right_val;
		end else if (cmd.insert && ins) begin
			val_q <= left_ins ? left_val : new_val;
		end
	end

endmodule

// ===== sv/insertion_sorter.sv =====
// Timing: a value is inserted in the cycle of its transfer; results of a run start
//   the cycle after the transfer of the final item, one per cycle while m_axis_tready is high.
// Throughput: one value per cycle while filling; a run of stored values is then drained,
//   during which no input is accepted (the single chain of cells).
// Reset: arst_n asynchronously empties the chain, clears the overflow flag and returns to fill.
`timescale 1ns / 1ps

module insertion_sorter import ins_sort_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic        s_axis_tlast,   // final_item
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
	output logic        m_axis_tlast,   // run_end
	output logic        m_axis_tuser    // [0] dropped
);

	ins_sort_state_t state_q, state_d;
	ins_sort_cmd_t   cmd;
	logic            overflow_q;
	logic            in_xfer, out_xfer, full;

	logic [DEPTH-1:0]             ins_w;
	logic [DEPTH-1:0]             vld_w;
	logic signed [DATA_W-1:0]     val_w [DEPTH];

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign full     = vld_w[DEPTH-1];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL:  if (in_xfer && s_axis_tlast) state_d = ST_DRAIN;
			ST_DRAIN: if (out_xfer && m_axis_tlast) state_d = ST_FILL;
			default:  state_d = ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs of the control FSM
	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_FILL: begin
				s_axis_tready = 1'b1;
				cmd.insert    = in_xfer && !full;
			end
			ST_DRAIN: begin
				m_axis_tvalid = 1'b1;
				cmd.shift     = out_xfer;
			end
			default: ;
		endcase
	end

	// Overflow flag: set on a dropped value, cleared after the run drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
		end else if (out_xfer && m_axis_tlast) begin
			overflow_q <= 1'b0;
		end else if (in_xfer && full) begin
			overflow_q <= 1'b1;
		end
	end

	// Chain of compare-and-shift cells, cell 0 is the head (smallest value)
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     l_ins, l_vld, r_vld;
		logic signed [DATA_W-1:0] l_val, r_val;

		if (i == 0) begin : g_head
			assign l_ins = 1'b0;
			assign l_vld = 1'b0;
			assign l_val = '0;
		end else begin : g_mid
			assign l_ins = ins_w[i-1];
			assign l_vld = vld_w[i-1];
			assign l_val = val_w[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign r_vld = 1'b0;
			assign r_val = '0;
		end else begin : g_body
			assign r_vld = vld_w[i+1];
			assign r_val = val_w[i+1];
		end

		ins_sort_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.new_val   ($signed(s_axis_tdata)),
			.left_ins  (l_ins),
			.left_vld  (l_vld),
			.left_val  (l_val),
			.right_vld (r_vld),
			.right_val (r_val),
			.ins       (ins_w[i]),
			.vld       (vld_w[i]),
			.val       (val_w[i])
		);
	end

	// Result comes straight from the head cell
	assign m_axis_tdata = val_w[0];
	assign m_axis_tlast = !vld_w[1];
	assign m_axis_tuser = overflow_q;

	// Occupied cells always form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_w & (vld_w + DEPTH'(1))) == '0)
		else $error("occupied cells not contiguous from head");

	// The head holds a value whenever a result is offered
	a_head_vld: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> vld_w[0])
		else $error("result offered from empty head cell");

	// Overflow while filling implies the chain is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && overflow_q) |-> full)
		else $error("overflow flagged without full chain");

	// The last result empties the chain and clears the overflow flag
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_axis_tlast) |=> (vld_w == '0 && !overflow_q))
		else $error("chain not empty after last result");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ins_sort_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;

	// one value waiting to go out on the input stream
	typedef struct {
		logic [31:0] val;
		logic        last;
		logic        hold;   // wait for every pending result before this transfer
	} sort_item_t;

	// one result the block still owes
	typedef struct {
		logic [31:0] val;
		logic        last;
		logic        drop;
	} sorted_result_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;   // [31:0] value
	logic        s_axis_tlast  = 1'b0; // final_item
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // [31:0] sorted_value
	logic        m_axis_tlast;         // run_end
	logic        m_axis_tuser;         // [0] dropped

	sort_item_t     item_queue[$];
	sorted_result_t sorted_due[$];

	// predictor state: the ascending store and its bookkeeping
	logic signed [31:0] run_store [DEPTH];
	int                 run_fill     = 0;
	logic               run_overflow = 1'b0;

	int err_count     = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int runs_done     = 0;
	int dropped_runs  = 0;
	int cycle_count   = 0;

	insertion_sorter #(.DEPTH(DEPTH)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// insert one value ahead of the first stored value >= it, or mark overflow when full; on the final item queue the run
	task automatic sort_and_expect(input logic signed [31:0] v, input logic last);
		int pos;
		int k;
		sorted_result_t r;
		if (run_fill < DEPTH) begin
			pos = 0;
			while (pos < run_fill && run_store[pos] < v)
				pos++;
			for (k = run_fill; k > pos; k--)
				run_store[k] = run_store[k - 1];
			run_store[pos] = v;
			run_fill++;
		end else begin
			run_overflow = 1'b1;
		end
		if (last) begin
			for (k = 0; k < run_fill; k++) begin
				r.val  = run_store[k];
				r.last = (k == run_fill - 1);
				r.drop = run_overflow;
				sorted_due.push_back(r);
			end
			runs_done++;
			if (run_overflow)
				dropped_runs++;
			run_fill     = 0;
			run_overflow = 1'b0;
		end
	endtask

	task automatic add_item(input logic [31:0] v, input logic last, input logic hold);
		sort_item_t it;
		it.val  = v;
		it.last = last;
		it.hold = hold;
		item_queue.push_back(it);
	endtask

	// mostly full-range values, some clustered near zero for ties, some extremes
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(9))
			6, 7:    v = $urandom_range(6) - 3;
			8:       v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// input driver: hold until transfer, then present the next pending item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				sort_and_expect(s_axis_tdata, s_axis_tlast);
				item_queue.pop_front();
				items_sent++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// keep the item stable until it is taken
			end else if (item_queue.size() != 0
					&& (!item_queue[0].hold || sorted_due.size() == 0)
					&& ((items_sent >= 20 && items_sent < 100) || $urandom_range(99) >= 8)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= item_queue[0].val;
				s_axis_tlast  <= item_queue[0].last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output monitor: compare each transfer with the oldest owed result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (sorted_due.size() == 0) begin
					err_count++;
					$display("%0t: unexpected: expected none, got %0d last %0b drop %0b",
						$realtime, $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
				end else begin
					if (m_axis_tdata !== sorted_due[0].val || m_axis_tlast !== sorted_due[0].last
							|| m_axis_tuser !== sorted_due[0].drop) begin
						err_count++;
						$display("%0t: mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							$realtime, $signed(sorted_due[0].val), sorted_due[0].last,
							sorted_due[0].drop, $signed(m_axis_tdata), m_axis_tlast,
							m_axis_tuser);
					end
					sorted_due.pop_front();
				end
			end
			m_axis_tready <= (results_seen >= 30 && results_seen < 110) || ($urandom_range(99) >= 8);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items and %0d results outstanding",
				$realtime, item_queue.size(), sorted_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int i;
		int len;
		int small_items;

		// directed: extremes and ties around zero
		add_item(32'h7FFF_FFFF, 1'b0, 1'b0);
		add_item(32'h8000_0000, 1'b0, 1'b0);
		add_item(32'h0000_0000, 1'b0, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_item(32'h0000_0001, 1'b0, 1'b0);
		add_item(32'h0000_0000, 1'b1, 1'b0);
		// a run of one value
		add_item(32'h8000_0000, 1'b1, 1'b0);
		// equal values with a smaller one between
		add_item(32'd5, 1'b0, 1'b0);
		add_item(32'd5, 1'b0, 1'b0);
		add_item(-32'sd5, 1'b0, 1'b0);
		add_item(32'd5, 1'b1, 1'b0);
		// descending then ascending input
		add_item(32'd3, 1'b0, 1'b0);
		add_item(32'd2, 1'b0, 1'b0);
		add_item(32'd1, 1'b1, 1'b0);
		add_item(32'd1, 1'b0, 1'b0);
		add_item(32'd2, 1'b0, 1'b0);
		add_item(32'd3, 1'b1, 1'b0);

		// store filled exactly, starting only after the block has drained
		for (i = 0; i < DEPTH; i++)
			add_item(pick_value(), i == DEPTH - 1, i == 0);
		// overflow: the last values, the final one too, are dropped
		for (i = 0; i < DEPTH + 3; i++)
			add_item(pick_value(), i == DEPTH + 2, i == 0);

		// short random runs
		small_items = 0;
		while (small_items < 32) begin
			len = $urandom_range(1, 10);
			for (i = 0; i < len; i++)
				add_item(pick_value(), i == len - 1, 1'b0);
			small_items += len;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (item_queue.size() != 0 || sorted_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d values in %0d runs, %0d of them overflowing the %0d-entry store;",
			items_sent, runs_done, dropped_runs, DEPTH);
		$display("checked %0d sorted results under random stalls on both streams.", results_seen);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors", err_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
